@@ sv/chs_remap_pkg.sv @@
`timescale 1ns / 1ps
package chs_remap_pkg;

   localparam int BLOCK_W = 28;
   localparam int CYL_W = 16;
   localparam int DIV_CNT_W = $clog2(BLOCK_W);

   localparam int TABLE_DEPTH_DEFAULT = 128;
   localparam int DRIVE_COUNT_DEFAULT = 2;

   localparam logic [CYL_W-1:0] END_MARK = 16'hFFFF;

   localparam logic [27:0] SPC_RESET = 28'd1999999;
   localparam logic [7:0] SPT_RESET = 8'd17;
   localparam logic [27:0] TOTAL_RESET = 28'd0;
   localparam logic [7:0] THRESHOLD_RESET = 8'd16;

   typedef enum logic [1:0] {
      CSR_SECTORS_PER_CYLINDER = 2'd0,
      CSR_SECTORS_PER_TRACK = 2'd1,
      CSR_TOTAL_SECTORS = 2'd2,
      CSR_REMAP_THRESHOLD = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_TRANSLATE = 1'b0,
      MODE_LOAD = 1'b1
   } mode_type;

   typedef struct packed {
      logic mode;
      logic drive;
      logic [27:0] block;
      logic [6:0] entry_index;
      logic [15:0] entry_cylinder;
      logic [15:0] entry_track_sector;
   } chs_req_type;

   typedef struct packed {
      logic [15:0] cylinder;
      logic [3:0] head;
      logic [7:0] sector_number;
      logic [27:0] final_block;
      logic remapped;
   } chs_rsp_type;

   typedef struct packed {
      logic start;
      logic [BLOCK_W-1:0] dividend;
      logic [BLOCK_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [BLOCK_W-1:0] quotient;
      logic [BLOCK_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic cyl_en;
      logic ts_en;
      logic [CYL_W-1:0] cyl;
      logic [15:0] ts;
   } tbl_wr_type;

endpackage

@@ sv/block_to_chs_bad_sector_remap.sv @@
`timescale 1ns / 1ps
// Channel   Ports                           Transfer
// request   start, busy, req_data           start high while busy low
// result    rsp_valid, rsp_data             one cycle strobe, no back-pressure
// config    csr_valid, csr_ready, csr_*     valid and ready high (ready tied high)
//
// A load item is written to the table as it is accepted. A translate item runs
// three divisions on the shared divider, plus a read state and a check state per
// table entry walked (one memory read each), plus three more divisions when the
// entry matches and the address is split again. After reset a clearing pass over
// TABLE_DEPTH * DRIVE_COUNT slots sets every cylinder slot to the end marker; busy
// is high meanwhile. Results cannot be stalled.
module block_to_chs_bad_sector_remap
   import chs_remap_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int DRIVE_COUNT = DRIVE_COUNT_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input chs_req_type req_data,
   output logic rsp_valid,
   output chs_rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [1:0] csr_index,
   input logic [27:0] csr_data
);

   localparam int DEPTH_ALL = TABLE_DEPTH * DRIVE_COUNT;
   localparam int AW = (DEPTH_ALL > 1) ? $clog2(DEPTH_ALL) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CYL,
      S_HEAD,
      S_SEC,
      S_WALK_RD,
      S_WALK_CHK,
      S_OUT
   } state_type;

   state_type state_ff;
   logic [AW-1:0] clr_ff;

   logic [27:0] spc_ff;
   logic [7:0] spt_ff;
   logic [27:0] total_ff;
   logic [7:0] thr_ff;

   logic drive_ff;
   logic drive_ok_ff;
   logic remap_ff;
   logic [27:0] blk_ff;
   logic [27:0] cyl_ff;
   logic [27:0] hd_ff;
   logic [7:0] sec_ff;
   logic [CW-1:0] idx_ff;

   div_req_type div_req_ff;
   div_rsp_type div_rsp;

   logic rsp_valid_ff;
   chs_rsp_type rsp_ff;

   logic accept;
   logic load_ok;
   logic [27:0] spc_eff;
   logic [27:0] spt_eff;
   logic [AW-1:0] req_base;
   logic [AW-1:0] walk_base;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   tbl_wr_type tbl_wr;
   logic [CYL_W-1:0] rd_cyl;
   logic [15:0] rd_ts;
   logic walk_stop;
   logic walk_hit;
   logic [27:0] spare_blk;

   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // a zero divisor acts as one
   assign spc_eff = (spc_ff == '0) ? 28'd1 : spc_ff;
   assign spt_eff = (spt_ff == '0) ? 28'd1 : 28'(spt_ff);

   assign req_base = req_data.drive ? AW'(TABLE_DEPTH) : '0;
   assign walk_base = drive_ff ? AW'(TABLE_DEPTH) : '0;
   assign load_ok = (32'(req_data.drive) < DRIVE_COUNT)
                    && (32'(req_data.entry_index) < TABLE_DEPTH);

   always_comb begin
      tbl_wr = '0;
      if (state_ff == S_CLEAR) begin
         wr_addr = clr_ff;
         tbl_wr.cyl_en = 1'b1;
         tbl_wr.cyl = END_MARK;
      end else begin
         wr_addr = req_base + AW'(req_data.entry_index);
         tbl_wr.cyl_en = accept && (req_data.mode == MODE_LOAD) && load_ok;
         tbl_wr.ts_en = tbl_wr.cyl_en;
         tbl_wr.cyl = req_data.entry_cylinder;
         tbl_wr.ts = req_data.entry_track_sector;
      end
   end

   assign rd_addr = walk_base + AW'(idx_ff);

   // full-width compare: a head of 256 or more never matches
   assign walk_stop = (rd_cyl == END_MARK) || (28'(rd_cyl) > cyl_ff);
   assign walk_hit = (28'(rd_cyl) == cyl_ff) && (hd_ff[27:8] == '0)
                     && ({hd_ff[7:0], sec_ff} == rd_ts);
   assign spare_blk = total_ff - 28'(spt_ff) - 28'(idx_ff) - 28'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         spc_ff <= SPC_RESET;
         spt_ff <= SPT_RESET;
         total_ff <= TOTAL_RESET;
         thr_ff <= THRESHOLD_RESET;
         div_req_ff.start <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_req_ff.start <= 1'b0;
         rsp_valid_ff <= 1'b0;

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SECTORS_PER_CYLINDER: spc_ff <= csr_data;
               CSR_SECTORS_PER_TRACK: spt_ff <= csr_data[7:0];
               CSR_TOTAL_SECTORS: total_ff <= csr_data;
               CSR_REMAP_THRESHOLD: thr_ff <= csr_data[7:0];
               default: ;
            endcase
         end

         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(DEPTH_ALL - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept && (req_data.mode == MODE_TRANSLATE)) begin
                  drive_ff <= req_data.drive;
                  drive_ok_ff <= (32'(req_data.drive) < DRIVE_COUNT);
                  blk_ff <= req_data.block;
                  remap_ff <= 1'b0;
                  div_req_ff.start <= 1'b1;
                  div_req_ff.dividend <= req_data.block;
                  div_req_ff.divisor <= spc_eff;
                  state_ff <= S_CYL;
               end
            end
            S_CYL: begin
               if (div_rsp.done) begin
                  cyl_ff <= div_rsp.quotient;
                  div_req_ff.start <= 1'b1;
                  div_req_ff.dividend <= div_rsp.remainder;
                  div_req_ff.divisor <= spt_eff;
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: begin
               if (div_rsp.done) begin
                  hd_ff <= div_rsp.quotient;
                  div_req_ff.start <= 1'b1;
                  div_req_ff.dividend <= blk_ff;
                  div_req_ff.divisor <= spt_eff;
                  state_ff <= S_SEC;
               end
            end
            S_SEC: begin
               if (div_rsp.done) begin
                  sec_ff <= div_rsp.remainder[7:0];
                  idx_ff <= '0;
                  if (!remap_ff && (blk_ff > 28'(thr_ff)) && drive_ok_ff) begin
                     state_ff <= S_WALK_RD;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_WALK_RD: begin
               state_ff <= S_WALK_CHK;
            end
            S_WALK_CHK: begin
               if (walk_stop) begin
                  state_ff <= S_OUT;
               end else if (walk_hit) begin
                  // redirect into the spare area and split again
                  blk_ff <= spare_blk;
                  remap_ff <= 1'b1;
                  div_req_ff.start <= 1'b1;
                  div_req_ff.dividend <= spare_blk;
                  div_req_ff.divisor <= spc_eff;
                  state_ff <= S_CYL;
               end else if (idx_ff == CW'(TABLE_DEPTH - 1)) begin
                  state_ff <= S_OUT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_WALK_RD;
               end
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.cylinder <= cyl_ff[15:0];
               rsp_ff.head <= hd_ff[3:0];
               rsp_ff.sector_number <= sec_ff + 8'd1;
               rsp_ff.final_block <= blk_ff;
               rsp_ff.remapped <= remap_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   chs_remap_div u_div (
      .clock(clock),
      .reset(reset),
      .div_req(div_req_ff),
      .div_rsp(div_rsp)
   );

   chs_remap_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .DRIVE_COUNT(DRIVE_COUNT)
   ) u_table (
      .clock(clock),
      .wr_addr(wr_addr),
      .wr(tbl_wr),
      .rd_addr(rd_addr),
      .rd_cyl(rd_cyl),
      .rd_ts(rd_ts)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ sv/chs_remap_div.sv @@
`timescale 1ns / 1ps
module chs_remap_div
   import chs_remap_pkg::*;
(
   input logic clock,
   input logic reset,
   input div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic run_ff;
   logic done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [BLOCK_W-1:0] quo_ff;
   logic [BLOCK_W-1:0] rem_ff;
   logic [BLOCK_W-1:0] dvs_ff;

   logic [BLOCK_W:0] trial;
   logic [BLOCK_W:0] diff;
   logic take;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[BLOCK_W-1]};
      diff = trial - {1'b0, dvs_ff};
      take = ~diff[BLOCK_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start && !run_ff) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            quo_ff <= div_req.dividend;
            rem_ff <= '0;
            dvs_ff <= div_req.divisor;
         end else if (run_ff) begin
            quo_ff <= {quo_ff[BLOCK_W-2:0], take};
            rem_ff <= take ? diff[BLOCK_W-1:0] : trial[BLOCK_W-1:0];
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(BLOCK_W - 1)) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

@@ sv/chs_remap_table.sv @@
`timescale 1ns / 1ps
module chs_remap_table
   import chs_remap_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int DRIVE_COUNT = DRIVE_COUNT_DEFAULT,
   localparam int DEPTH_ALL = TABLE_DEPTH * DRIVE_COUNT,
   localparam int AW = (DEPTH_ALL > 1) ? $clog2(DEPTH_ALL) : 1
) (
   input logic clock,
   input logic [AW-1:0] wr_addr,
   input tbl_wr_type wr,
   input logic [AW-1:0] rd_addr,
   output logic [CYL_W-1:0] rd_cyl,
   output logic [15:0] rd_ts
);

   logic [CYL_W-1:0] cyl_mem [DEPTH_ALL];
   logic [15:0] ts_mem [DEPTH_ALL];
   logic [CYL_W-1:0] rd_cyl_ff;
   logic [15:0] rd_ts_ff;

   always_ff @(posedge clock) begin
      if (wr.cyl_en) begin
         cyl_mem[wr_addr] <= wr.cyl;
      end
      if (wr.ts_en) begin
         ts_mem[wr_addr] <= wr.ts;
      end
      rd_cyl_ff <= cyl_mem[rd_addr];
      rd_ts_ff <= ts_mem[rd_addr];
   end

   assign rd_cyl = rd_cyl_ff;
   assign rd_ts = rd_ts_ff;

endmodule
